// ----- hdl/kmd_pkg.sv -----
package kmd_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned TICK_W = 8;

    localparam logic [OP_W-1:0] OP_ROW_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK       = 2'd1;
    localparam logic [OP_W-1:0] OP_END_SCAN   = 2'd2;

    localparam logic [TICK_W-1:0] TICK_MAX          = 8'd255;
    localparam logic [TICK_W-1:0] DEBOUNCE_MS_RESET = 8'd5;

    typedef struct packed {
        logic row_changed;
        logic debouncing;
        logic committed;
    } t_flags;

endpackage

// ----- hdl/kmd_core.sv -----
module kmd_core #(
    parameter int unsigned ROWS  = 7,
    parameter int unsigned COLS  = 13,
    parameter int unsigned IDX_W = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [kmd_pkg::OP_W-1:0]    i_op,
    input  logic [IDX_W-1:0]            i_idx,
    input  logic [COLS-1:0]             i_lines,
    input  logic [kmd_pkg::TICK_W-1:0]  i_debounce_ms,
    output logic [COLS-1:0]             o_stable_row,
    output kmd_pkg::t_flags             o_flags
);

    logic [COLS-1:0]            r_stable  [ROWS];
    logic [COLS-1:0]            r_pending [ROWS];
    logic                       r_change_pending;
    logic [kmd_pkg::TICK_W-1:0] r_quiet_ticks;

    logic [kmd_pkg::TICK_W-1:0] n_quiet_ticks;
    logic                       n_change_pending;

    logic            row_ok;
    logic [COLS-1:0] cols;
    logic [COLS-1:0] pend_row;
    logic            changed;
    logic            commit;

    assign row_ok   = ({1'b0, i_idx} < (IDX_W + 1)'(ROWS));
    assign cols     = ~i_lines;
    assign pend_row = row_ok ? r_pending[i_idx] : '0;
    assign changed  = (i_op == kmd_pkg::OP_ROW_SAMPLE) && row_ok && (pend_row != cols);
    assign commit   = (i_op == kmd_pkg::OP_END_SCAN) && r_change_pending
                      && (r_quiet_ticks >= i_debounce_ms);

    always_comb begin
        n_quiet_ticks    = r_quiet_ticks;
        n_change_pending = r_change_pending;
        if (changed) begin
            n_quiet_ticks    = '0;
            n_change_pending = 1'b1;
        end else if (i_op == kmd_pkg::OP_TICK && r_quiet_ticks != kmd_pkg::TICK_MAX) begin
            n_quiet_ticks = r_quiet_ticks + 1'b1;
        end else if (commit) begin
            n_change_pending = 1'b0;
        end
    end

    // stable row after the step: a commit exposes the pending copy right away
    always_comb begin
        if (!row_ok) begin
            o_stable_row = '0;
        end else if (commit) begin
            o_stable_row = pend_row;
        end else begin
            o_stable_row = r_stable[i_idx];
        end
    end

    assign o_flags.row_changed = changed;
    assign o_flags.debouncing  = n_change_pending;
    assign o_flags.committed   = commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_stable[r]  <= '0;
                r_pending[r] <= '0;
            end
            r_change_pending <= 1'b0;
            r_quiet_ticks    <= '0;
        end else if (i_fire) begin
            r_change_pending <= n_change_pending;
            r_quiet_ticks    <= n_quiet_ticks;
            if (changed) begin
                r_pending[i_idx] <= cols;
            end
            if (commit) begin
                for (int r = 0; r < ROWS; r++) begin
                    r_stable[r] <= r_pending[r];
                end
            end
        end
    end

endmodule

// ----- hdl/key_matrix_debounce.sv -----
// Pipeline: an accepted transaction passes the input register, then the result register that drives o_valid.
// Throughput: one transaction per cycle; the input register hands to the result register
// every cycle unless the result register is held by i_stall.
// Reset (synchronous, active low): both matrices, the debouncing flag and the tick counter
// clear, debounce_ms returns to 5, and both pipeline registers empty.
module key_matrix_debounce #(
    parameter int unsigned ROWS = 7,
    parameter int unsigned COLS = 13
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [kmd_pkg::OP_W-1:0]               i_op,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] i_row_index,
    input  logic [COLS-1:0]                        i_column_lines,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [COLS-1:0]                        o_stable_row,
    output logic                                   o_row_changed,
    output logic                                   o_debouncing,
    output logic                                   o_committed,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [kmd_pkg::TICK_W-1:0]             i_cfg_data
);

    localparam int unsigned IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                       r_in_valid;
    logic [kmd_pkg::OP_W-1:0]   r_op;
    logic [IDX_W-1:0]           r_idx;
    logic [COLS-1:0]            r_lines;
    logic                       r_out_valid;
    logic [COLS-1:0]            r_stable_row;
    kmd_pkg::t_flags            r_flags;
    logic [kmd_pkg::TICK_W-1:0] r_debounce_ms;

    logic            out_free;
    logic            fire;
    logic            in_take;
    logic [COLS-1:0] core_row;
    kmd_pkg::t_flags core_flags;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    kmd_core #(
        .ROWS  (ROWS),
        .COLS  (COLS),
        .IDX_W (IDX_W)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_op          (r_op),
        .i_idx         (r_idx),
        .i_lines       (r_lines),
        .i_debounce_ms (r_debounce_ms),
        .o_stable_row  (core_row),
        .o_flags       (core_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= kmd_pkg::DEBOUNCE_MS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce_ms <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_op;
            r_idx   <= i_row_index;
            r_lines <= i_column_lines;
        end
    end

    // hold the result while stalled; advance whenever the result register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_stable_row <= core_row;
            r_flags      <= core_flags;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_stable_row  = r_stable_row;
    assign o_row_changed = r_flags.row_changed;
    assign o_debouncing  = r_flags.debouncing;
    assign o_committed   = r_flags.committed;

endmodule

// ----- bench/key_matrix_debounce_tb.sv -----
module key_matrix_debounce_tb;

    localparam int unsigned ROWS = 7;
    localparam int unsigned COLS = 13;
    localparam int unsigned ROW_W = 3;

    // op code the block leaves alone
    localparam logic [kmd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [COLS-1:0] stable_row;
        kmd_pkg::t_flags flags;
    } t_scan_result;

    typedef struct packed {
        logic [kmd_pkg::OP_W-1:0] op;
        logic [ROW_W-1:0]         row;
        logic [COLS-1:0]          lines;
        logic                     fixed;
        t_scan_result             want;
    } t_scan_vec;

    // want = {stable_row, {row_changed, debouncing, committed}}
    localparam t_scan_vec DIRECTED_SCANS [24] = '{
        '{kmd_pkg::OP_END_SCAN,    3'd0, 13'h0000, 1'b1, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_ROW_SAMPLE,  3'd0, 13'h1FFF, 1'b1, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_ROW_SAMPLE,  3'd0, 13'h0000, 1'b1, {13'h0000, 3'b110}},
        '{kmd_pkg::OP_END_SCAN,    3'd0, 13'h0000, 1'b1, {13'h0000, 3'b010}},
        '{kmd_pkg::OP_TICK,        3'd0, 13'h0000, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd0, 13'h1FFF, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd0, 13'h0000, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd0, 13'h1FFF, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd0, 13'h0000, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_END_SCAN,    3'd0, 13'h0000, 1'b1, {13'h1FFF, 3'b001}},
        '{kmd_pkg::OP_ROW_SAMPLE,  3'd7, 13'h0000, 1'b1, {13'h0000, 3'b000}},
        '{OP_UNUSED,               3'd0, 13'h1234, 1'b1, {13'h1FFF, 3'b000}},
        '{kmd_pkg::OP_ROW_SAMPLE,  3'd6, 13'h1555, 1'b1, {13'h0000, 3'b110}},
        '{kmd_pkg::OP_END_SCAN,    3'd6, 13'h0000, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd7, 13'h0000, 1'b1, {13'h0000, 3'b010}},
        '{kmd_pkg::OP_TICK,        3'd3, 13'h1FFF, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd3, 13'h0F0F, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd3, 13'h10F0, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_TICK,        3'd3, 13'h0000, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_ROW_SAMPLE,  3'd6, 13'h1555, 1'b0, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_END_SCAN,    3'd6, 13'h0000, 1'b1, {13'h0AAA, 3'b001}},
        '{kmd_pkg::OP_END_SCAN,    3'd7, 13'h1FFF, 1'b1, {13'h0000, 3'b000}},
        '{kmd_pkg::OP_ROW_SAMPLE,  3'd3, 13'h0000, 1'b0, {13'h0000, 3'b000}},
        '{OP_UNUSED,               3'd7, 13'h1FFF, 1'b0, {13'h0000, 3'b000}}
    };

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_stall;
    logic [kmd_pkg::OP_W-1:0]   i_op           = kmd_pkg::OP_ROW_SAMPLE;
    logic [ROW_W-1:0]           i_row_index    = '0;
    logic [COLS-1:0]            i_column_lines = '1;
    logic                       o_valid;
    logic                       i_stall        = 1'b0;
    logic [COLS-1:0]            o_stable_row;
    logic                       o_row_changed;
    logic                       o_debouncing;
    logic                       o_committed;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [kmd_pkg::TICK_W-1:0] i_cfg_data     = '0;

    // predictor state
    logic [COLS-1:0]            stable_rows [ROWS];
    logic [COLS-1:0]            pend_rows   [ROWS];
    logic                       change_armed;
    logic [kmd_pkg::TICK_W-1:0] quiet_count;
    logic [kmd_pkg::TICK_W-1:0] settle_ticks;

    t_scan_result expected_scans [$];
    int unsigned  mismatch_count = 0;
    int unsigned  items_sent     = 0;
    int unsigned  burst_left     = 0;
    logic [COLS-1:0] key_lines [ROWS];

    key_matrix_debounce #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_row_index    (i_row_index),
        .i_column_lines (i_column_lines),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_stable_row   (o_stable_row),
        .o_row_changed  (o_row_changed),
        .o_debouncing   (o_debouncing),
        .o_committed    (o_committed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_scan_result debounce_predict(input logic [kmd_pkg::OP_W-1:0] op,
                                                      input logic [ROW_W-1:0] row,
                                                      input logic [COLS-1:0] lines);
        t_scan_result    res;
        logic            in_range;
        logic [COLS-1:0] pressed;
        res      = '0;
        in_range = (row < ROWS);
        pressed  = ~lines;
        case (op)
            kmd_pkg::OP_ROW_SAMPLE: begin
                if (in_range) begin
                    if (pend_rows[row] != pressed) begin
                        pend_rows[row]        = pressed;
                        change_armed          = 1'b1;
                        quiet_count           = '0;
                        res.flags.row_changed = 1'b1;
                    end
                end
            end
            kmd_pkg::OP_TICK: begin
                if (quiet_count != kmd_pkg::TICK_MAX) quiet_count = quiet_count + 1'b1;
            end
            kmd_pkg::OP_END_SCAN: begin
                if (change_armed && quiet_count >= settle_ticks) begin
                    for (int r = 0; r < ROWS; r++) stable_rows[r] = pend_rows[r];
                    change_armed        = 1'b0;
                    res.flags.committed = 1'b1;
                end
            end
            default: ;
        endcase
        res.stable_row       = in_range ? stable_rows[row] : '0;
        res.flags.debouncing = change_armed;
        return res;
    endfunction

    task automatic send_item(input logic [kmd_pkg::OP_W-1:0] op, input logic [ROW_W-1:0] row,
                             input logic [COLS-1:0] lines, input logic fixed,
                             input t_scan_result want);
        t_scan_result predicted;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 20);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_row_index    <= row;
        i_column_lines <= lines;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = debounce_predict(op, row, lines);
        expected_scans.push_back(fixed ? want : predicted);
        burst_left--;
        // ignored transactions do not count toward the budget
        if (op != OP_UNUSED && !(op == kmd_pkg::OP_ROW_SAMPLE && row >= ROWS)) items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [kmd_pkg::TICK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        settle_ticks = value;
        i_cfg_valid <= 1'b0;
    endtask

    // one scan pass: every row, a run of ticks, then end of scan
    task automatic scan_pass();
        int unsigned     r;
        int unsigned     b;
        int unsigned     n;
        logic [COLS-1:0] lines;
        if ($urandom_range(0, 9) < 4) begin
            r = $urandom_range(0, ROWS - 1);
            b = $urandom_range(0, COLS - 1);
            key_lines[r][b] = ~key_lines[r][b];
        end
        for (r = 0; r < ROWS; r++) begin
            lines = key_lines[r];
            // contact bounce
            if ($urandom_range(0, 9) == 0) begin
                b = $urandom_range(0, COLS - 1);
                lines[b] = ~lines[b];
            end
            send_item(kmd_pkg::OP_ROW_SAMPLE, ROW_W'(r), lines, 1'b0, '0);
        end
        n = $urandom_range(0, settle_ticks / 2 + 8);
        repeat (n) send_item(kmd_pkg::OP_TICK, ROW_W'($urandom_range(0, 7)), COLS'($urandom),
                             1'b0, '0);
        send_item(kmd_pkg::OP_END_SCAN, ROW_W'($urandom_range(0, 7)), COLS'($urandom),
                  1'b0, '0);
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) scan_pass();
            else send_item((kmd_pkg::OP_W)'($urandom_range(0, 3)),
                           ROW_W'($urandom_range(0, 7)), COLS'($urandom), 1'b0, '0);
            if ($urandom_range(0, 49) == 0) drain();
        end
    endtask

    // receiver: stall on a randomly chosen mode, check each transaction
    int unsigned stall_mode = 0;
    int unsigned cyc        = 0;

    always @(posedge i_clk) begin
        t_scan_result exp_scan;
        cyc = cyc + 1;
        if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 4) == 0);
            2:       i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((cyc % 8) < 3);
        endcase
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_scans.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: stable_row=%h changed=%b deb=%b com=%b",
                             o_stable_row, o_row_changed, o_debouncing, o_committed);
            end else begin
                exp_scan = expected_scans.pop_front();
                if (o_stable_row !== exp_scan.stable_row
                    || o_row_changed !== exp_scan.flags.row_changed
                    || o_debouncing !== exp_scan.flags.debouncing
                    || o_committed !== exp_scan.flags.committed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: stable_row %h/%h changed %b/%b deb %b/%b com %b/%b",
                                 exp_scan.stable_row, o_stable_row,
                                 exp_scan.flags.row_changed, o_row_changed,
                                 exp_scan.flags.debouncing, o_debouncing,
                                 exp_scan.flags.committed, o_committed);
                end
            end
        end
    end

    initial begin
        logic [kmd_pkg::TICK_W-1:0] phase_thr [6];
        for (int r = 0; r < ROWS; r++) begin
            stable_rows[r] = '0;
            pend_rows[r]   = '0;
            key_lines[r]   = '1;
        end
        change_armed = 1'b0;
        quiet_count  = '0;
        settle_ticks = kmd_pkg::DEBOUNCE_MS_RESET;
        phase_thr    = '{8'd0, 8'd1, 8'd255, 8'd0, 8'd3, 8'd5};
        phase_thr[3] = 8'($urandom_range(2, 254));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_SCANS[k])
            send_item(DIRECTED_SCANS[k].op, DIRECTED_SCANS[k].row, DIRECTED_SCANS[k].lines,
                      DIRECTED_SCANS[k].fixed, DIRECTED_SCANS[k].want);

        // top threshold: the counter must saturate and still commit
        drain();
        write_threshold(8'd255);
        send_item(kmd_pkg::OP_ROW_SAMPLE, 3'd1, 13'h0000, 1'b0, '0);
        repeat (300) send_item(kmd_pkg::OP_TICK, ROW_W'($urandom_range(0, 7)),
                               COLS'($urandom), 1'b0, '0);
        send_item(kmd_pkg::OP_END_SCAN, 3'd1, 13'h0000, 1'b0, '0);

        foreach (phase_thr[p]) begin
            drain();
            write_threshold(phase_thr[p]);
            run_random(270);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_scans.size() == 0)
            $display("key_matrix_debounce regression: pass");
        else
            $display("key_matrix_debounce regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("key_matrix_debounce regression: fail");
        $finish;
    end

endmodule
